>>> src/hsvba_pkg.sv
// shared types and constants for the hsv brightness adjust block
package hsvba_pkg;

    localparam int PORT_W   = 16;
    localparam int AMOUNT_W = 10;

    localparam logic [AMOUNT_W-1:0] PCT_SCALE = AMOUNT_W'(100);
    localparam logic [AMOUNT_W-1:0] HALF_PCT  = AMOUNT_W'(50);

    localparam logic OP_DARKER  = 1'b0;
    localparam logic OP_LIGHTER = 1'b1;

    typedef struct packed {
        logic                operation;
        logic [PORT_W-1:0]   red;
        logic [PORT_W-1:0]   green;
        logic [PORT_W-1:0]   blue;
        logic [PORT_W-1:0]   alpha;
        logic [AMOUNT_W-1:0] amount;
    } in_word_t;

    typedef struct packed {
        logic [PORT_W-1:0] out_red;
        logic [PORT_W-1:0] out_green;
        logic [PORT_W-1:0] out_blue;
        logic [PORT_W-1:0] out_alpha;
    } out_word_t;

endpackage

>>> src/hsvba_div_cell.sv
// one restoring division step: one quotient bit per cell, registered
module hsvba_div_cell #(
    parameter int DEN_W  = 10,
    parameter int Q_W    = 16,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [DEN_W-1:0]  in_rem,
    input  logic [Q_W-1:0]    in_nq,
    input  logic [DEN_W-1:0]  in_den,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [DEN_W-1:0]  out_rem,
    output logic [Q_W-1:0]    out_nq,
    output logic [DEN_W-1:0]  out_den,
    output logic [SIDE_W-1:0] out_side
);

    logic              valid_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [DEN_W-1:0]  rem_next;
    logic [Q_W-1:0]    nq_reg;
    logic [Q_W-1:0]    nq_next;
    logic [DEN_W-1:0]  den_reg;
    logic [SIDE_W-1:0] side_reg;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              ge;

    // numerator bits shift out at the top, quotient bits shift in at the bottom
    always_comb
    begin
        trial    = {in_rem, in_nq[Q_W-1]};
        diff     = trial - {1'b0, in_den};
        ge       = (trial >= {1'b0, in_den});
        rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        nq_next  = {in_nq[Q_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        nq_reg   <= nq_next;
        den_reg  <= in_den;
        side_reg <= in_side;
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_nq    = nq_reg;
    assign out_den   = den_reg;
    assign out_side  = side_reg;

endmodule

>>> src/hsvba_div_chain.sv
// row of division cells giving a Q_W-bit quotient, one word per clock
module hsvba_div_chain #(
    parameter int DEN_W  = 10,
    parameter int Q_W    = 16,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [DEN_W-1:0]  in_rem,
    input  logic [Q_W-1:0]    in_nq,
    input  logic [DEN_W-1:0]  in_den,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [Q_W-1:0]    out_q,
    output logic [SIDE_W-1:0] out_side
);

    logic              valid_a [0:Q_W];
    logic [DEN_W-1:0]  rem_a   [0:Q_W];
    logic [Q_W-1:0]    nq_a    [0:Q_W];
    logic [DEN_W-1:0]  den_a   [0:Q_W];
    logic [SIDE_W-1:0] side_a  [0:Q_W];

    assign valid_a[0] = in_valid;
    assign rem_a[0]   = in_rem;
    assign nq_a[0]    = in_nq;
    assign den_a[0]   = in_den;
    assign side_a[0]  = in_side;

    for (genvar i = 0; i < Q_W; i++)
    begin : g_cell
        hsvba_div_cell #(
            .DEN_W  (DEN_W),
            .Q_W    (Q_W),
            .SIDE_W (SIDE_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (valid_a[i]),
            .in_rem    (rem_a[i]),
            .in_nq     (nq_a[i]),
            .in_den    (den_a[i]),
            .in_side   (side_a[i]),
            .out_valid (valid_a[i+1]),
            .out_rem   (rem_a[i+1]),
            .out_nq    (nq_a[i+1]),
            .out_den   (den_a[i+1]),
            .out_side  (side_a[i+1])
        );
    end

    assign out_valid = valid_a[Q_W];
    assign out_q     = nq_a[Q_W];
    assign out_side  = side_a[Q_W];

    // a well-formed start remainder must end as a proper remainder
    a_rem_final: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && $past(in_valid, Q_W) && $past(in_rem < in_den, Q_W)
        |-> rem_a[Q_W] < den_a[Q_W])
        else $error("division remainder not below divisor");

    a_valid_delay: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $past(in_valid, Q_W))
        else $error("division word without matching input");

    a_den_carried: assert property (@(posedge clk) disable iff (!rst_n)
        valid_a[1] |-> den_a[1] == $past(in_den))
        else $error("divisor not carried along the row");

endmodule

>>> src/hsv_brightness_adjust.sv
// hsv brightness adjust top level: value scaling of one rgba pixel
// Takes one pixel per clock and never stalls: busy is always low. Each word
// appears on pixel_out with done high, from the output register, after two
// rows of divider cells, one quotient bit per cell: the first row forms the
// scaled value, the second rescales red, green and blue by new value over
// old value in three lanes.
module hsv_brightness_adjust
    import hsvba_pkg::*;
#(
    parameter int CHANNEL_BITS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  in_word_t  pixel_in,
    output logic      done,
    output out_word_t pixel_out
);

    localparam int N     = CHANNEL_BITS;
    localparam int NUM_W = N + AMOUNT_W;
    localparam int S1_W  = 5 * N + 2;
    localparam int LAT   = 2 * N + 4;
    localparam logic [N-1:0] FULL = {N{1'b1}};

    // input register
    logic     s1_valid_reg;
    in_word_t s1_word_reg;

    // value and first numerator
    logic [N-1:0]        r1, g1, b1, a1, v1;
    logic [AMOUNT_W-1:0] mul_b;
    logic [NUM_W-1:0]    num1_next;
    logic                s2_valid_reg;
    logic [NUM_W-1:0]    num1_reg;
    logic [AMOUNT_W-1:0] den1_reg;
    logic [N-1:0]        r2_reg, g2_reg, b2_reg, a2_reg, v2_reg;
    logic                ovf;

    // first row
    logic           c1_valid;
    logic [N-1:0]   c1_q;
    logic [S1_W-1:0] c1_side;
    logic           c1_ovf, c1_zero;
    logic [N-1:0]   c1_v, c1_r, c1_g, c1_b, c1_a, vn;

    // rescale products
    logic           s3_valid_reg;
    logic [2*N-1:0] num_r_reg, num_g_reg, num_b_reg;
    logic [N-1:0]   v3_reg, a3_reg;
    logic           zero3_reg;

    // second row lanes
    logic           cr_valid, cg_valid, cb_valid;
    logic [N-1:0]   qr, qg, qb;
    logic [N:0]     sr;
    logic           zg, zb;

    logic      done_reg;
    out_word_t out_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start && !busy;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= c1_valid;
            done_reg     <= cr_valid;
        end
    end

    always_comb
    begin
        r1 = N'(s1_word_reg.red);
        g1 = N'(s1_word_reg.green);
        b1 = N'(s1_word_reg.blue);
        a1 = N'(s1_word_reg.alpha);
        v1 = r1;
        if (g1 > v1)
        begin
            v1 = g1;
        end
        if (b1 > v1)
        begin
            v1 = b1;
        end
        // lighter: v*amount + 50 over 100, darker: v*100 + amount/2 over amount
        mul_b = (s1_word_reg.operation == OP_LIGHTER) ? s1_word_reg.amount : PCT_SCALE;
        num1_next = NUM_W'({{AMOUNT_W{1'b0}}, v1} * {{N{1'b0}}, mul_b})
                  + ((s1_word_reg.operation == OP_LIGHTER) ? NUM_W'(HALF_PCT)
                                                           : NUM_W'(s1_word_reg.amount >> 1));
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            s1_word_reg <= pixel_in;
        end
        num1_reg <= num1_next;
        den1_reg <= (s1_word_reg.operation == OP_LIGHTER) ? PCT_SCALE : s1_word_reg.amount;
        r2_reg   <= r1;
        g2_reg   <= g1;
        b2_reg   <= b1;
        a2_reg   <= a1;
        v2_reg   <= v1;
    end

    // quotient of 2^N or more saturates; a zero divisor always lands here
    assign ovf = (num1_reg[NUM_W-1:N] >= den1_reg);

    hsvba_div_chain #(
        .DEN_W  (AMOUNT_W),
        .Q_W    (N),
        .SIDE_W (S1_W)
    ) u_value_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid_reg),
        .in_rem    (num1_reg[NUM_W-1:N]),
        .in_nq     (num1_reg[N-1:0]),
        .in_den    (den1_reg),
        .in_side   ({ovf, (v2_reg == '0), v2_reg, r2_reg, g2_reg, b2_reg, a2_reg}),
        .out_valid (c1_valid),
        .out_q     (c1_q),
        .out_side  (c1_side)
    );

    assign {c1_ovf, c1_zero, c1_v, c1_r, c1_g, c1_b, c1_a} = c1_side;
    assign vn = c1_ovf ? FULL : c1_q;

    always_ff @(posedge clk)
    begin
        num_r_reg <= ({{N{1'b0}}, c1_r} * {{N{1'b0}}, vn}) + (2*N)'(c1_v >> 1);
        num_g_reg <= ({{N{1'b0}}, c1_g} * {{N{1'b0}}, vn}) + (2*N)'(c1_v >> 1);
        num_b_reg <= ({{N{1'b0}}, c1_b} * {{N{1'b0}}, vn}) + (2*N)'(c1_v >> 1);
        v3_reg    <= c1_v;
        a3_reg    <= c1_a;
        zero3_reg <= c1_zero;
    end

    hsvba_div_chain #(
        .DEN_W  (N),
        .Q_W    (N),
        .SIDE_W (N + 1)
    ) u_red_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s3_valid_reg),
        .in_rem    (num_r_reg[2*N-1:N]),
        .in_nq     (num_r_reg[N-1:0]),
        .in_den    (v3_reg),
        .in_side   ({zero3_reg, a3_reg}),
        .out_valid (cr_valid),
        .out_q     (qr),
        .out_side  (sr)
    );

    hsvba_div_chain #(
        .DEN_W  (N),
        .Q_W    (N),
        .SIDE_W (1)
    ) u_green_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s3_valid_reg),
        .in_rem    (num_g_reg[2*N-1:N]),
        .in_nq     (num_g_reg[N-1:0]),
        .in_den    (v3_reg),
        .in_side   (zero3_reg),
        .out_valid (cg_valid),
        .out_q     (qg),
        .out_side  (zg)
    );

    hsvba_div_chain #(
        .DEN_W  (N),
        .Q_W    (N),
        .SIDE_W (1)
    ) u_blue_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s3_valid_reg),
        .in_rem    (num_b_reg[2*N-1:N]),
        .in_nq     (num_b_reg[N-1:0]),
        .in_den    (v3_reg),
        .in_side   (zero3_reg),
        .out_valid (cb_valid),
        .out_q     (qb),
        .out_side  (zb)
    );

    // black pixel gives black whatever the divider produced
    always_ff @(posedge clk)
    begin
        out_reg.out_red   <= sr[N] ? '0 : PORT_W'(qr);
        out_reg.out_green <= zg    ? '0 : PORT_W'(qg);
        out_reg.out_blue  <= zb    ? '0 : PORT_W'(qb);
        out_reg.out_alpha <= PORT_W'(sr[N-1:0]);
    end

    assign done      = done_reg;
    assign pixel_out = out_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT))
        else $error("word delivered without a start");

    a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        cr_valid |-> (cg_valid && cb_valid && (zg == sr[N]) && (zb == sr[N])))
        else $error("rescale lanes out of step");

    a_rescale_fits: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg && !zero3_reg |->
            (num_r_reg[2*N-1:N] < v3_reg) && (num_g_reg[2*N-1:N] < v3_reg)
            && (num_b_reg[2*N-1:N] < v3_reg))
        else $error("rescale quotient would not fit");

    a_darker_zero: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && (den1_reg == '0) |-> ovf)
        else $error("zero amount did not saturate");

endmodule
